>>> rtl/rnp_pkg.sv
// Shared types, constants and the character-to-digit decode for the radix number parser.
package rnp_pkg;

   localparam int unsigned RADIX_W = 6;
   localparam int unsigned VALUE_W = 64;

   localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_DEFAULT = 6'd10;

   // Digit code for a character that is no digit at all; above any radix.
   localparam logic [RADIX_W-1:0] DIGIT_NONE = 6'h3F;

   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_0       = 8'h30;
   localparam logic [7:0] CHAR_9       = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] LETTER_BASE  = 8'd10;

   typedef struct packed {
      logic [7:0] char_code;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      ok;
   } rsp_type;

   // Map one byte to its digit value 0..35, or DIGIT_NONE.
   function automatic logic [RADIX_W-1:0] digit_of(input logic [7:0] c);
      logic [7:0] d;
      d = 8'h00;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         d = c - CHAR_0;
         return d[RADIX_W-1:0];
      end
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         d = c - CHAR_UPPER_A + LETTER_BASE;
         return d[RADIX_W-1:0];
      end
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         d = c - CHAR_LOWER_A + LETTER_BASE;
         return d[RADIX_W-1:0];
      end
      return DIGIT_NONE;
   endfunction

endpackage

>>> rtl/rnp_token_acc.sv
// Token state and the per-character multiply-add that builds the parsed value.
module rnp_token_acc (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  rnp_pkg::req_type       item,
   input  logic [rnp_pkg::RADIX_W-1:0] radix,
   output rnp_pkg::rsp_type       result
);
   import rnp_pkg::*;

   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic               negative_ff, negative_in;
   logic               seen_ff, seen_in;
   logic               start_ff, start_in;
   logic               bad_ff, bad_in;

   logic               is_sign;
   logic [RADIX_W-1:0] digit;
   logic               digit_bad;
   logic [VALUE_W-1:0] digit_ext;
   logic [VALUE_W-1:0] sum;
   logic               tok_ok;

   // Decode: a sign is only a sign as the first character of a token
   assign is_sign   = start_ff &&
                      (item.char_code == CHAR_PLUS || item.char_code == CHAR_MINUS);
   assign digit     = digit_of(item.char_code);
   assign digit_bad = (digit == DIGIT_NONE) || (digit >= radix);

   // The accumulator carries the sign already applied: -(a*r+d) = (-a)*r - d,
   // so the final negate never follows the multiply in the same path.
   assign digit_ext = {{(VALUE_W-RADIX_W){1'b0}}, digit};
   assign sum = acc_ff * {{(VALUE_W-RADIX_W){1'b0}}, radix}
              + (negative_ff ? (~digit_ext + 64'd1) : digit_ext);

   // Next token state for the current character
   always_comb begin
      acc_in      = acc_ff;
      negative_in = negative_ff;
      seen_in     = seen_ff;
      bad_in      = bad_ff;
      start_in    = 1'b0;
      if (is_sign) begin
         negative_in = (item.char_code == CHAR_MINUS);
      end else if (!bad_ff) begin
         if (digit_bad) begin
            bad_in = 1'b1;
         end else begin
            acc_in  = sum;
            seen_in = 1'b1;
         end
      end
   end

   // Result seen on the last character of a token
   assign tok_ok       = !bad_in && seen_in;
   assign result.ok    = tok_ok;
   assign result.value = tok_ok ? acc_in : '0;

   // Token state; the last character returns it to the start of a token
   always_ff @(posedge clock) begin
      if (reset || (step && item.is_last)) begin
         acc_ff      <= '0;
         negative_ff <= 1'b0;
         seen_ff     <= 1'b0;
         start_ff    <= 1'b1;
         bad_ff      <= 1'b0;
      end else if (step) begin
         acc_ff      <= acc_in;
         negative_ff <= negative_in;
         seen_ff     <= seen_in;
         start_ff    <= start_in;
         bad_ff      <= bad_in;
      end
   end

endmodule

>>> rtl/radix_number_parser_top.sv
// Top level of the radix number parser: input register, token accumulator, result register.
// Parses a signed integer token, one character per item, in a radix of 2 to 36 set through
// the csr port (out-of-range writes store 10). A leading + or - sets the sign; 0-9, A-Z and
// a-z are digits 0..35. The item flagged is_last yields one result: the value (wrapping
// modulo 2^64) and ok, or 0 with ok low for a bad or digitless token. Throughput is one
// item per cycle while the input does not stall. An accepted item waits in the input
// register while the 64-by-6 multiply-add runs, and the result of a last character is
// captured in the result register, which raises rsp_valid. The input stalls only when
// a result waits in the output register, is not taken that cycle, and the next last
// character sits in the input register.
module radix_number_parser_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  rnp_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output rnp_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rnp_pkg::RADIX_W-1:0]   csr_data
);
   import rnp_pkg::*;

   logic               in_valid_ff;
   req_type            in_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   logic [RADIX_W-1:0] radix_ff, radix_in;

   logic               out_free;
   logic               advance;
   rsp_type            result;

   // Radix register, coerced on write
   assign csr_ready = 1'b1;
   assign radix_in  = (csr_data < RADIX_MIN || csr_data > RADIX_MAX) ? RADIX_DEFAULT
                                                                     : csr_data;
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_DEFAULT;
      end else if (csr_valid) begin
         radix_ff <= radix_in;
      end
   end

   // Flow control: only a last character needs room in the result register
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!in_ff.is_last || out_free);
   assign req_ready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_ff <= req_data;
      end
   end

   rnp_token_acc u_acc (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_ff),
      .radix  (radix_ff),
      .result (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_ff.is_last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && in_ff.is_last) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> tb/number_checker.sv
// Checker for the radix number parser: predicts each parsed number and compares results.
module number_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  rnp_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  rnp_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [rnp_pkg::RADIX_W-1:0]   csr_data,
   output int                            mismatches,
   output int                            outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import rnp_pkg::*;

   // Predicted token state and current base
   logic [VALUE_W-1:0] acc;
   logic               minus_seen;
   logic               any_digit;
   logic               first_char;
   logic               token_bad;
   logic [RADIX_W-1:0] base;

   rsp_type expected_numbers [$];
   rsp_type oldest;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
   endtask

   // Digit value of a byte, -1 when it is no digit
   function automatic int char_digit(input logic [7:0] c);
      if (c >= CHAR_0 && c <= CHAR_9) return int'(c) - int'(CHAR_0);
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return int'(c) - int'(CHAR_UPPER_A) + 10;
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) return int'(c) - int'(CHAR_LOWER_A) + 10;
      return -1;
   endfunction

   task automatic clear_token();
      acc        = '0;
      minus_seen = 1'b0;
      any_digit  = 1'b0;
      first_char = 1'b1;
      token_bad  = 1'b0;
   endtask

   // Fold one accepted character into the token; queue a number on the last one
   task automatic absorb_char(input req_type item);
      int      d;
      rsp_type res;
      if (first_char && (item.char_code == CHAR_PLUS || item.char_code == CHAR_MINUS)) begin
         minus_seen = (item.char_code == CHAR_MINUS);
      end else if (!token_bad) begin
         d = char_digit(item.char_code);
         if (d < 0 || d >= int'(base)) begin
            token_bad = 1'b1;
         end else begin
            acc       = acc * VALUE_W'(base) + VALUE_W'(d);
            any_digit = 1'b1;
         end
      end
      first_char = 1'b0;
      if (item.is_last) begin
         res.ok    = !token_bad && any_digit;
         res.value = '0;
         if (res.ok) res.value = minus_seen ? -acc : acc;
         expected_numbers.push_back(res);
         clear_token();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_token();
         base = RADIX_DEFAULT;
         expected_numbers.delete();
         mismatches = 0;
      end else begin
         // Results first: a number queued this edge cannot leave this edge
         if (rsp_valid && rsp_ready) begin
            if (expected_numbers.size() == 0) begin
               report_mismatch($sformatf("unexpected result value=%h ok=%b",
                                         rsp_data.value, rsp_data.ok));
            end else begin
               oldest = expected_numbers.pop_front();
               if (rsp_data.value !== oldest.value)
                  report_mismatch($sformatf("value %h, expected %h",
                                            rsp_data.value, oldest.value));
               if (rsp_data.ok !== oldest.ok)
                  report_mismatch($sformatf("ok %b, expected %b", rsp_data.ok, oldest.ok));
            end
         end
         // Out-of-range bases fall back to the default
         if (csr_valid && csr_ready)
            base = (csr_data < RADIX_MIN || csr_data > RADIX_MAX) ? RADIX_DEFAULT : csr_data;
         if (req_valid && req_ready) absorb_char(req_data);
      end
      outstanding = expected_numbers.size();
   end

endmodule

>>> tb/tb_top.sv
// Top of the radix number parser testbench: clock, reset, stimulus and verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rnp_pkg::*;

   logic               clock;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   req_type            req_data  = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   rsp_type            rsp_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [RADIX_W-1:0] csr_data  = '0;

   int mismatches;
   int outstanding;

   int tx_idle_pct = 25;
   int rx_idle_pct = 50;
   int hold_cycles = 0;
   int items_sent  = 0;
   logic [RADIX_W-1:0] cur_radix = RADIX_DEFAULT;

   radix_number_parser_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   number_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Result side: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Offer one character; valid stays up after acceptance for the next item
   task automatic send_char(input logic [7:0] c, input logic last);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{char_code: c, is_last: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int k = 0; k < s.len(); k++) send_char(s[k], k == s.len() - 1);
   endtask

   // Drop valid, let every number drain and the pipe settle
   task automatic wait_quiet();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_radix(input logic [RADIX_W-1:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_radix = (v < RADIX_MIN || v > RADIX_MAX) ? RADIX_DEFAULT : v;
      @(posedge clock);
   endtask

   // Token with optional sign and digits valid in the current base, maybe one byte spoiled
   task automatic send_number(input int ndigits, input bit spoil);
      logic [7:0] text [$];
      int         d;
      int         sel;
      int         pos;
      sel = $urandom_range(2);
      if (sel == 1) text.push_back(CHAR_PLUS);
      else if (sel == 2) text.push_back(CHAR_MINUS);
      for (int k = 0; k < ndigits; k++) begin
         d = $urandom_range(int'(cur_radix) - 1);
         if (d < 10) text.push_back(8'(int'(CHAR_0) + d));
         else if ($urandom_range(1)) text.push_back(8'(int'(CHAR_UPPER_A) + d - 10));
         else text.push_back(8'(int'(CHAR_LOWER_A) + d - 10));
      end
      if (text.size() == 0) text.push_back(8'($urandom_range(255)));
      if (spoil) begin
         pos = $urandom_range(text.size() - 1);
         text[pos] = 8'($urandom_range(255));
      end
      for (int k = 0; k < text.size(); k++) send_char(text[k], k == text.size() - 1);
   endtask

   initial begin
      int roll;
      int len;
      int start;
      int ntok;
      int guard;
      logic [RADIX_W-1:0] pick;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: signs alone, sign placement, byte extremes, bases and their extremes
      send_text("+");
      send_text("-");
      send_text("9");
      send_text("-z");
      send_text("1-");
      send_char(8'hFF, 1'b1);
      send_char(8'h00, 1'b1);
      send_text("+7");
      wait_quiet();
      write_radix(RADIX_MAX);
      send_text("-Zz");
      wait_quiet();
      write_radix(6'd63);
      send_text("a");
      wait_quiet();
      write_radix(RADIX_MIN);
      send_text("12");
      send_text("-1");
      // base changes in the middle of a token
      send_char(CHAR_0 + 8'd1, 1'b0);
      wait_quiet();
      write_radix(RADIX_MAX);
      send_text("Z");
      wait_quiet();
      write_radix(6'd0);
      write_radix(6'd1);
      write_radix(6'd37);
      send_text("-09");

      // Random: mostly well-formed numbers, some spoiled tokens and raw noise
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin tx_idle_pct = 25; rx_idle_pct = 50; end
            1: begin tx_idle_pct = 50; rx_idle_pct = 25; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
         endcase
         start = items_sent;
         ntok  = 0;
         while (items_sent - start < 235) begin
            if (ntok % 12 == 0) begin
               wait_quiet();
               roll = $urandom_range(99);
               if (roll < 10) pick = $urandom_range(1) ? RADIX_MIN : RADIX_MAX;
               else if (roll < 25) pick = RADIX_W'($urandom_range(63));
               else pick = RADIX_W'($urandom_range(36, 2));
               write_radix(pick);
            end
            // long receiver hold-off while characters keep coming
            if (phase == 2 && ntok == 1) hold_cycles = 300;
            len = ($urandom_range(99) < 15) ? $urandom_range(20, 7) : $urandom_range(6);
            roll = $urandom_range(99);
            if (roll < 80) begin
               send_number(len, 1'b0);
            end else if (roll < 90) begin
               send_number(len, 1'b1);
            end else begin
               len = $urandom_range(4, 1);
               for (int k = 0; k < len; k++)
                  send_char(8'($urandom_range(255)), k == len - 1);
            end
            ntok++;
         end
      end

      // Drain and decide
      req_valid <= 1'b0;
      guard = 0;
      do begin
         @(negedge clock);
         guard++;
      end while (outstanding != 0 && guard < 20000);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
